/* rtl/dsa_pkg.sv */
// Shared types and codes for the dual stack ALU unit.
package dsa_pkg;

  localparam logic [3:0] MODE_PUSH    = 4'd0;
  localparam logic [3:0] MODE_POP     = 4'd1;
  localparam logic [3:0] MODE_ADD     = 4'd2;
  localparam logic [3:0] MODE_SUB     = 4'd3;
  localparam logic [3:0] MODE_DUP     = 4'd4;
  localparam logic [3:0] MODE_SWAP    = 4'd5;
  localparam logic [3:0] MODE_ROT     = 4'd6;
  localparam logic [3:0] MODE_LESS    = 4'd7;
  localparam logic [3:0] MODE_EQUAL   = 4'd8;
  localparam logic [3:0] MODE_GREATER = 4'd9;
  localparam logic [3:0] MODE_INVERT  = 4'd10;
  localparam logic [3:0] MODE_RPUSH   = 4'd11;
  localparam logic [3:0] MODE_RPOP    = 4'd12;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_DATA_UNDER = 3'd1;
  localparam logic [2:0] ST_RET_UNDER  = 3'd2;
  localparam logic [2:0] ST_FULL       = 3'd3;
  localparam logic [2:0] ST_HALTED     = 3'd4;

  localparam logic [15:0] WORD_TRUE  = 16'hFFFF;
  localparam logic [15:0] WORD_FALSE = 16'h0000;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_ROT_A,
    S_ROT_B
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic rot_a;
    logic rot_b;
  } dp_ctl_t;

  typedef struct packed {
    logic rot_go;
  } dp_sts_t;

endpackage

/* rtl/dsa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/dsa_ctrl.sv */
// Sequencing state machine for the dual stack ALU unit.
module dsa_ctrl import dsa_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  dp_sts_t sts,
  output dp_ctl_t ctl,
  output logic    busy,
  output logic    done
);

  state_t state, state_next;
  logic   done_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    ctl        = '0;
    busy       = 1'b1;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec = 1'b1;
        if (sts.rot_go) begin
          state_next = S_ROT_A;
        end else begin
          state_next = S_IDLE;
          done_next  = 1'b1;
        end
      end
      S_ROT_A: begin
        ctl.rot_a  = 1'b1;
        state_next = S_ROT_B;
      end
      S_ROT_B: begin
        ctl.rot_b  = 1'b1;
        state_next = S_IDLE;
        done_next  = 1'b1;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* rtl/dsa_datapath.sv */
// Stack datapath: top registers, counts, stack RAMs and the ALU.
module dsa_datapath import dsa_pkg::*; #(
  parameter int DATA_SLOTS   = 512,
  parameter int RETURN_SLOTS = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_ctl_t     ctl,
  output dp_sts_t     sts,
  input  logic [3:0]  mode,
  input  logic [15:0] operand,
  output logic [15:0] popped,
  output logic [2:0]  status,
  output logic [15:0] top_value,
  output logic [8:0]  data_depth,
  output logic [15:0] return_top_value,
  output logic [6:0]  return_depth
);

  localparam int DAW = $clog2(DATA_SLOTS);
  localparam int RAW = $clog2(RETURN_SLOTS);
  localparam logic [DAW-1:0] DFULL = DAW'(DATA_SLOTS - 1);
  localparam logic [RAW-1:0] RFULL = RAW'(RETURN_SLOTS - 1);

  logic [3:0]     op_mode;
  logic [15:0]    op_val;
  logic [DAW-1:0] dcount, dcount_next;
  logic [RAW-1:0] rcount, rcount_next;
  logic [15:0]    dtop, dtop_next;
  logic [15:0]    rtop, rtop_next;
  logic [15:0]    tmp, tmp_next;
  logic           halted, halted_next;
  logic [15:0]    popped_next;
  logic [2:0]     status_next;

  logic           dwe, rwe;
  logic [DAW-1:0] dwaddr, draddr;
  logic [RAW-1:0] rwaddr, rraddr;
  logic [15:0]    dwdata, rwdata, drdata, rrdata;
  logic [15:0]    alu;

  dsa_ram #(.WIDTH(16), .DEPTH(DATA_SLOTS)) u_dram (
    .clk   (clk),
    .we    (dwe),
    .waddr (dwaddr),
    .wdata (dwdata),
    .raddr (draddr),
    .rdata (drdata)
  );

  dsa_ram #(.WIDTH(16), .DEPTH(RETURN_SLOTS)) u_rram (
    .clk   (clk),
    .we    (rwe),
    .waddr (rwaddr),
    .wdata (rwdata),
    .raddr (rraddr),
    .rdata (rrdata)
  );

  assign draddr = ctl.exec ? dcount - DAW'(3) : dcount - DAW'(2);
  assign rraddr = rcount - RAW'(2);

  assign sts.rot_go = !halted && (op_mode == MODE_ROT) && (dcount >= DAW'(3));

  // second is drdata, top is dtop
  always_comb begin
    unique case (op_mode)
      MODE_ADD:   alu = drdata + dtop;
      MODE_SUB:   alu = drdata - dtop;
      MODE_LESS:  alu = (drdata < dtop) ? WORD_TRUE : WORD_FALSE;
      MODE_EQUAL: alu = (drdata == dtop) ? WORD_TRUE : WORD_FALSE;
      default:    alu = (drdata > dtop) ? WORD_TRUE : WORD_FALSE;
    endcase
  end

  always_comb begin
    dcount_next = dcount;
    rcount_next = rcount;
    dtop_next   = dtop;
    rtop_next   = rtop;
    tmp_next    = tmp;
    halted_next = halted;
    popped_next = popped;
    status_next = status;
    dwe    = 1'b0;
    dwaddr = dcount - DAW'(1);
    dwdata = dtop;
    rwe    = 1'b0;
    rwaddr = rcount - RAW'(1);
    rwdata = rtop;

    if (ctl.exec) begin
      popped_next = WORD_FALSE;
      status_next = ST_OK;
      if (halted) begin
        status_next = ST_HALTED;
      end else begin
        unique case (op_mode)
          MODE_PUSH, MODE_DUP: begin
            if (dcount == DFULL) begin
              status_next = ST_FULL;
            end else begin
              dwe         = (dcount != '0);
              dcount_next = dcount + DAW'(1);
              if (op_mode == MODE_PUSH) begin
                dtop_next = op_val;
              end else if (dcount == '0) begin
                dtop_next = WORD_FALSE;
              end
            end
          end
          MODE_POP: begin
            if (dcount == '0) begin
              status_next = ST_DATA_UNDER;
            end else begin
              popped_next = dtop;
              dtop_next   = drdata;
              dcount_next = dcount - DAW'(1);
            end
          end
          MODE_ADD, MODE_SUB, MODE_LESS, MODE_EQUAL, MODE_GREATER: begin
            if (dcount < DAW'(2)) begin
              status_next = ST_DATA_UNDER;
            end else begin
              dtop_next   = alu;
              dcount_next = dcount - DAW'(1);
            end
          end
          MODE_SWAP: begin
            if (dcount >= DAW'(2)) begin
              dwe       = 1'b1;
              dwaddr    = dcount - DAW'(2);
              dtop_next = drdata;
            end
          end
          MODE_ROT: begin
            if (dcount >= DAW'(3)) begin
              tmp_next  = dtop;
              dtop_next = drdata;
            end
          end
          MODE_INVERT: begin
            if (dcount == '0) begin
              status_next = ST_DATA_UNDER;
            end else begin
              dtop_next = ~dtop;
            end
          end
          MODE_RPUSH: begin
            if (rcount == RFULL) begin
              status_next = ST_FULL;
            end else begin
              rwe         = (rcount != '0);
              rtop_next   = op_val;
              rcount_next = rcount + RAW'(1);
            end
          end
          MODE_RPOP: begin
            if (rcount == '0) begin
              status_next = ST_RET_UNDER;
            end else begin
              popped_next = rtop;
              rtop_next   = rrdata;
              rcount_next = rcount - RAW'(1);
            end
          end
          default: ;
        endcase
        if (status_next == ST_DATA_UNDER || status_next == ST_RET_UNDER) begin
          halted_next = 1'b1;
        end
      end
    end else if (ctl.rot_a) begin
      dwe    = 1'b1;
      dwaddr = dcount - DAW'(2);
      dwdata = drdata;
    end else if (ctl.rot_b) begin
      dwe    = 1'b1;
      dwaddr = dcount - DAW'(3);
      dwdata = tmp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dcount <= '0;
      rcount <= '0;
      halted <= 1'b0;
    end else begin
      dcount <= dcount_next;
      rcount <= rcount_next;
      halted <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_mode <= mode;
      op_val  <= operand;
    end
    dtop   <= dtop_next;
    rtop   <= rtop_next;
    tmp    <= tmp_next;
    popped <= popped_next;
    status <= status_next;
  end

  assign top_value        = (dcount != '0) ? dtop : WORD_FALSE;
  assign return_top_value = (rcount != '0) ? rtop : WORD_FALSE;
  assign data_depth       = 9'(dcount);
  assign return_depth     = 7'(rcount);

endmodule

/* rtl/dual_stack_alu_unit.sv */
// Top level of the dual stack ALU unit: data stack and return stack.
//
//   channel   handshake          word
//   -------   ----------------   ------------------------------------------
//   command   start, busy        mode, operand
//   result    done (strobe)      popped, status, top_value, data_depth,
//                                return_top_value, return_depth
//
// A command is accepted, then executed; rot with three or more items then
// passes ROT_A and ROT_B, moving two words through the single data RAM port.
// The result strobe rises the cycle after execution, and a new command may
// be accepted in that same cycle. Both stack tops live in registers, the
// rest in RAM. Reset empties both stacks and clears the halt.
// The done strobe is shown for one cycle only; the receiver cannot stall.
module dual_stack_alu_unit import dsa_pkg::*; #(
  parameter int DATA_SLOTS   = 512,
  parameter int RETURN_SLOTS = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  mode,
  input  logic [15:0] operand,
  output logic        done,
  output logic [15:0] popped,
  output logic [2:0]  status,
  output logic [15:0] top_value,
  output logic [8:0]  data_depth,
  output logic [15:0] return_top_value,
  output logic [6:0]  return_depth
);

  dp_ctl_t ctl;
  dp_sts_t sts;

  dsa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  dsa_datapath #(
    .DATA_SLOTS   (DATA_SLOTS),
    .RETURN_SLOTS (RETURN_SLOTS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .ctl              (ctl),
    .sts              (sts),
    .mode             (mode),
    .operand          (operand),
    .popped           (popped),
    .status           (status),
    .top_value        (top_value),
    .data_depth       (data_depth),
    .return_top_value (return_top_value),
    .return_depth     (return_depth)
  );

endmodule
